// ===== src/brp_pkg.sv =====
// Package for the box-to-image rectangle projection unit.
// Field widths, register indexes, the corner tag type and the divider sizes.
`timescale 1ns / 1ps
package brp_pkg;

   localparam int CORNER_COUNT = 8;
   localparam int CORNER_W     = $clog2(CORNER_COUNT);

   localparam int COORD_W   = 16;   // Q8.8 box bounds
   localparam int COEF_W    = 32;   // Q15.16 matrix elements
   localparam int COEF_NUM  = 12;
   localparam int PAIR_NUM  = 6;
   localparam int PROD_W    = COEF_W + COORD_W;  // one coefficient times one coordinate
   localparam int TRANS_W   = COEF_W + 8;        // translation element scaled by 256
   localparam int SUM_W     = 49;                // |X|, |Y|, |W| stay below 2^48
   localparam int PIX_W     = 16;   // Q12.4 outputs
   localparam int MIN_DEPTH_W  = 24;
   localparam int IMG_SIZE_W   = 32;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_INDEX_W  = 3;

   localparam int DIVIDEND_W = SUM_W + 4;        // X * 16
   localparam int DIVISOR_W  = SUM_W - 1;        // positive depth
   localparam int QUOT_W     = DIVIDEND_W + 1;   // signed quotient

   localparam logic [IMG_SIZE_W-1:0]  IMAGE_SIZE_RESET = 32'd70780800;
   localparam logic [PIX_W-1:0]       PIX_MAX = 16'hFFFF;

   localparam logic [CSR_INDEX_W-1:0] REG_COEF_PAIR_0 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_COEF_PAIR_5 = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_SIZE  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_DEPTH   = 3'd7;

   typedef struct packed {
      logic used;   // corner passed the depth test
      logic last;   // final corner of its box
   } corner_tag_type;

endpackage

// ===== src/box_to_image_rect_projection_unit.sv =====
// Box-to-image rectangle projection unit, top level.
// Depends on brp_pkg and the pipelined divider brp_div.
`timescale 1ns / 1ps
// A box transaction is taken on req_*, its eight corners are projected through the 3x4
// matrix in csr registers 0..5, and one rectangle transaction leaves on rsp_*. The corner
// sequencer issues one corner per cycle while the pipe is not stalled, and a new box is
// taken in the cycle its last corner issues, so the corners of the next box follow on.
// Four register stages form X, Y and W, each of the two pipelined dividers (u and v)
// has an entry stage, 53 quotient-bit stages and a sign restore stage, and min/max, clip
// and the output register follow. Corners flow behind valid bits; the whole pipe freezes
// while a held result is stalled, so nothing is lost or repeated. Corners with depth not
// positive or below min_depth are carried through marked unused. Configure only while idle.
module box_to_image_rect_projection_unit (
   input  logic                                     clock,
   input  logic                                     reset,
   // configuration
   input  logic                                     csr_write_enable,
   input  logic [brp_pkg::CSR_INDEX_W-1:0]          csr_index,
   input  logic [brp_pkg::CSR_DATA_W-1:0]           csr_write_data,
   // box input
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [brp_pkg::COORD_W-1:0]       req_box_min_x,
   input  logic signed [brp_pkg::COORD_W-1:0]       req_box_max_x,
   input  logic signed [brp_pkg::COORD_W-1:0]       req_box_min_y,
   input  logic signed [brp_pkg::COORD_W-1:0]       req_box_max_y,
   input  logic signed [brp_pkg::COORD_W-1:0]       req_box_min_z,
   input  logic signed [brp_pkg::COORD_W-1:0]       req_box_max_z,
   // rectangle output
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic                                     rsp_rect_valid,
   output logic [brp_pkg::PIX_W-1:0]                rsp_rect_left,
   output logic [brp_pkg::PIX_W-1:0]                rsp_rect_top,
   output logic [brp_pkg::PIX_W-1:0]                rsp_rect_width,
   output logic [brp_pkg::PIX_W-1:0]                rsp_rect_height
);
   localparam int CW = brp_pkg::COORD_W;
   localparam int PW = brp_pkg::PROD_W;
   localparam int SW = brp_pkg::SUM_W;
   localparam int QW = brp_pkg::QUOT_W;
   localparam int XW = brp_pkg::PIX_W;

   // ---------------- configuration registers ----------------
   logic [brp_pkg::CSR_DATA_W-1:0]   coef_pair_ff [brp_pkg::PAIR_NUM];
   logic [brp_pkg::IMG_SIZE_W-1:0]   image_size_ff;
   logic [brp_pkg::MIN_DEPTH_W-1:0]  min_depth_ff;
   logic signed [brp_pkg::COEF_W-1:0] coef [brp_pkg::COEF_NUM];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < brp_pkg::PAIR_NUM; i++) begin
            coef_pair_ff[i] <= '0;
         end
         image_size_ff <= brp_pkg::IMAGE_SIZE_RESET;
         min_depth_ff  <= '0;
      end else if (csr_write_enable) begin
         if (csr_index == brp_pkg::REG_IMAGE_SIZE) begin
            image_size_ff <= csr_write_data[brp_pkg::IMG_SIZE_W-1:0];
         end else if (csr_index == brp_pkg::REG_MIN_DEPTH) begin
            min_depth_ff <= csr_write_data[brp_pkg::MIN_DEPTH_W-1:0];
         end else if (csr_index <= brp_pkg::REG_COEF_PAIR_5) begin
            coef_pair_ff[csr_index - brp_pkg::REG_COEF_PAIR_0] <= csr_write_data;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < brp_pkg::COEF_NUM; i++) begin
         coef[i] = (i % 2 == 1) ? coef_pair_ff[i/2][63:32] : coef_pair_ff[i/2][31:0];
      end
   end

   // ---------------- pipeline control ----------------
   // whole pipe advances unless a held result is stalled
   logic en;
   logic rsp_valid_ff;
   assign en = ~rsp_valid_ff | ~rsp_stall;

   // ---------------- corner sequencer ----------------
   logic signed [CW-1:0]            box_ff [6];
   logic [brp_pkg::CORNER_W-1:0]    cnt_ff;
   logic                            busy_ff;
   logic                            last_issue;
   logic                            req_take;

   assign last_issue = busy_ff & (cnt_ff == brp_pkg::CORNER_W'(brp_pkg::CORNER_COUNT - 1));
   assign req_stall  = ~(en & (~busy_ff | last_issue));
   assign req_take   = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (req_take) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (en & busy_ff) begin
         busy_ff <= ~last_issue;
         cnt_ff  <= cnt_ff + 1'b1;
      end
      if (req_take) begin
         box_ff[0] <= req_box_min_x;
         box_ff[1] <= req_box_max_x;
         box_ff[2] <= req_box_min_y;
         box_ff[3] <= req_box_max_y;
         box_ff[4] <= req_box_min_z;
         box_ff[5] <= req_box_max_z;
      end
   end

   // stage 0: corner coordinates
   logic                 c_valid_ff, c_last_ff;
   logic signed [CW-1:0] cx_ff, cy_ff, cz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= busy_ff;
      end
      if (en) begin
         c_last_ff <= last_issue;
         cx_ff     <= cnt_ff[2] ? box_ff[1] : box_ff[0];
         cy_ff     <= cnt_ff[1] ? box_ff[3] : box_ff[2];
         cz_ff     <= cnt_ff[0] ? box_ff[5] : box_ff[4];
      end
   end

   // stage 1: nine products, one per matrix element and coordinate
   logic                 p_valid_ff, p_last_ff;
   logic signed [PW-1:0] prod_ff [3][3];

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (en) begin
         p_valid_ff <= c_valid_ff;
      end
      if (en) begin
         p_last_ff <= c_last_ff;
         for (int r = 0; r < 3; r++) begin
            prod_ff[r][0] <= coef[4*r]   * cx_ff;
            prod_ff[r][1] <= coef[4*r+1] * cy_ff;
            prod_ff[r][2] <= coef[4*r+2] * cz_ff;
         end
      end
   end

   // stage 2: pair sums, translation scaled to Q.24 (sign kept)
   logic                 a_valid_ff, a_last_ff;
   logic signed [SW-1:0] pa_ff [3];
   logic signed [SW-1:0] pb_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= p_valid_ff;
      end
      if (en) begin
         a_last_ff <= p_last_ff;
         for (int r = 0; r < 3; r++) begin
            pa_ff[r] <= SW'(prod_ff[r][0]) + SW'(prod_ff[r][1]);
            pb_ff[r] <= SW'(prod_ff[r][2]) + SW'($signed({coef[4*r+3], 8'h00}));
         end
      end
   end

   // stage 3: X, Y and depth W
   logic                 s_valid_ff, s_last_ff;
   logic signed [SW-1:0] sx_ff, sy_ff, sw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else if (en) begin
         s_valid_ff <= a_valid_ff;
      end
      if (en) begin
         s_last_ff <= a_last_ff;
         sx_ff     <= pa_ff[0] + pb_ff[0];
         sy_ff     <= pa_ff[1] + pb_ff[1];
         sw_ff     <= pa_ff[2] + pb_ff[2];
      end
   end

   // depth test rides with the corner as a tag
   logic signed [SW-1:0]    depth_floor;
   brp_pkg::corner_tag_type s_tag;

   assign depth_floor = $signed(SW'({min_depth_ff, 8'h00}));
   assign s_tag.used  = (sw_ff > 0) && (sw_ff >= depth_floor);
   assign s_tag.last  = s_last_ff;

   // ---------------- u and v dividers ----------------
   logic                    du_valid, dv_valid;
   logic signed [QW-1:0]    du_quot, dv_quot;
   brp_pkg::corner_tag_type du_tag, dv_tag;

   brp_div u_div_u (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (s_valid_ff),
      .in_dividend ({sx_ff, 4'h0}),
      .in_divisor  (sw_ff[brp_pkg::DIVISOR_W-1:0]),
      .in_tag      (s_tag),
      .out_valid   (du_valid),
      .out_quot    (du_quot),
      .out_tag     (du_tag)
   );

   brp_div u_div_v (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (s_valid_ff),
      .in_dividend ({sy_ff, 4'h0}),
      .in_divisor  (sw_ff[brp_pkg::DIVISOR_W-1:0]),
      .in_tag      (s_tag),
      .out_valid   (dv_valid),
      .out_quot    (dv_quot),
      .out_tag     (dv_tag)
   );

   // ---------------- min / max over used corners ----------------
   logic                 any_ff;
   logic signed [QW-1:0] u0_ff, u1_ff, v0_ff, v1_ff;
   logic                 any_in;
   logic signed [QW-1:0] u0_in, u1_in, v0_in, v1_in;

   always_comb begin
      any_in = any_ff;
      u0_in  = u0_ff;
      u1_in  = u1_ff;
      v0_in  = v0_ff;
      v1_in  = v1_ff;
      if (du_tag.used) begin
         any_in = 1'b1;
         if (!any_ff || du_quot < u0_ff) u0_in = du_quot;
         if (!any_ff || du_quot > u1_ff) u1_in = du_quot;
         if (!any_ff || dv_quot < v0_ff) v0_in = dv_quot;
         if (!any_ff || dv_quot > v1_ff) v1_in = dv_quot;
      end
   end

   logic                 f_valid_ff, f_any_ff;
   logic signed [QW-1:0] fu0_ff, fu1_ff, fv0_ff, fv1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         any_ff     <= 1'b0;
         f_valid_ff <= 1'b0;
      end else if (en) begin
         f_valid_ff <= du_valid & du_tag.last;
         if (du_valid) begin
            any_ff <= any_in & ~du_tag.last;
         end
      end
      if (en & du_valid) begin
         u0_ff  <= u0_in;
         u1_ff  <= u1_in;
         v0_ff  <= v0_in;
         v1_ff  <= v1_in;
         f_any_ff <= any_in;
         fu0_ff <= u0_in;
         fu1_ff <= u1_in;
         fv0_ff <= v0_in;
         fv1_ff <= v1_in;
      end
   end

   // ---------------- clip to image ----------------
   logic [XW-1:0] lim_u, lim_v;
   logic [11:0]   img_w_lo, img_h_lo;

   assign img_w_lo = image_size_ff[11:0];
   assign img_h_lo = image_size_ff[27:16];
   assign lim_u = (|image_size_ff[15:12]) ? brp_pkg::PIX_MAX : {img_w_lo, 4'h0};
   assign lim_v = (|image_size_ff[31:28]) ? brp_pkg::PIX_MAX : {img_h_lo, 4'h0};

   // lower edge: raise to 0; values past the 16-bit range saturate, which keeps r <= l
   function automatic logic [XW-1:0] clip_lo(input logic signed [QW-1:0] val);
      logic [XW-1:0] res;
      if (val[QW-1])               res = '0;
      else if (|val[QW-2:XW])      res = brp_pkg::PIX_MAX;
      else                         res = val[XW-1:0];
      return res;
   endfunction

   // upper edge: lower to the image limit; negative becomes 0 and fails r > l
   function automatic logic [XW-1:0] clip_hi(input logic signed [QW-1:0] val,
                                             input logic [XW-1:0] lim);
      logic [XW-1:0] res;
      if (val[QW-1])                               res = '0;
      else if (|val[QW-2:XW] || val[XW-1:0] > lim) res = lim;
      else                                         res = val[XW-1:0];
      return res;
   endfunction

   logic          k_valid_ff, k_ok_ff;
   logic [XW-1:0] kl_ff, kt_ff, kr_ff, kb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_valid_ff <= 1'b0;
      end else if (en) begin
         k_valid_ff <= f_valid_ff;
      end
      if (en) begin
         k_ok_ff <= f_any_ff && (fu1_ff > fu0_ff) && (fv1_ff > fv0_ff);
         kl_ff   <= clip_lo(fu0_ff);
         kt_ff   <= clip_lo(fv0_ff);
         kr_ff   <= clip_hi(fu1_ff, lim_u);
         kb_ff   <= clip_hi(fv1_ff, lim_v);
      end
   end

   // ---------------- output register ----------------
   logic          good;
   logic          rect_valid_ff;
   logic [XW-1:0] left_ff, top_ff, width_ff, height_ff;

   assign good = k_ok_ff && (kr_ff > kl_ff) && (kb_ff > kt_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= k_valid_ff;
      end
      if (en) begin
         rect_valid_ff <= good;
         left_ff       <= good ? kl_ff : '0;
         top_ff        <= good ? kt_ff : '0;
         width_ff      <= good ? kr_ff - kl_ff : '0;
         height_ff     <= good ? kb_ff - kt_ff : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rect_valid  = rect_valid_ff;
   assign rsp_rect_left   = left_ff;
   assign rsp_rect_top    = top_ff;
   assign rsp_rect_width  = width_ff;
   assign rsp_rect_height = height_ff;

   // ---------------- assertions ----------------
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      (du_valid == dv_valid) && (!du_valid || du_tag == dv_tag))
      else $error("u and v dividers out of step");

   a_take_on_slot: assert property (@(posedge clock) disable iff (reset)
      req_take |-> (!busy_ff || last_issue))
      else $error("box taken while corners of previous box pending");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_rect_valid) |->
         (rsp_rect_left == '0 && rsp_rect_top == '0 &&
          rsp_rect_width == '0 && rsp_rect_height == '0))
      else $error("invalid rectangle carries nonzero fields");

   a_valid_nonempty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_rect_valid) |-> (rsp_rect_width != '0 && rsp_rect_height != '0))
      else $error("valid rectangle is empty");

endmodule

// ===== src/brp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, truncating toward zero.
// Depends on brp_pkg for widths and the corner tag type carried alongside.
`timescale 1ns / 1ps
module brp_div (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  logic                                   in_valid,
   input  logic signed [brp_pkg::DIVIDEND_W-1:0]  in_dividend,
   input  logic [brp_pkg::DIVISOR_W-1:0]          in_divisor,
   input  brp_pkg::corner_tag_type                in_tag,
   output logic                                   out_valid,
   output logic signed [brp_pkg::QUOT_W-1:0]      out_quot,
   output brp_pkg::corner_tag_type                out_tag
);
   localparam int N  = brp_pkg::DIVIDEND_W;
   localparam int DR = brp_pkg::DIVISOR_W;

   logic [N:0]                     valid_ff;
   logic [N:0]                     neg_ff;
   logic [DR-1:0]                  rem_ff  [0:N];
   logic [N-1:0]                   quo_ff  [0:N];
   logic [DR-1:0]                  dsor_ff [0:N];
   brp_pkg::corner_tag_type        tag_ff  [0:N];
   logic [N-1:0]                   mag_in;
   logic                           out_valid_ff;
   logic signed [brp_pkg::QUOT_W-1:0] out_quot_ff;
   brp_pkg::corner_tag_type        out_tag_ff;

   assign mag_in = in_dividend[N-1] ? N'(~in_dividend + 1'b1) : N'(in_dividend);

   // entry stage: magnitude and sign
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
      if (en) begin
         neg_ff[0]  <= in_dividend[N-1];
         rem_ff[0]  <= '0;
         quo_ff[0]  <= mag_in;
         dsor_ff[0] <= in_divisor;
         tag_ff[0]  <= in_tag;
      end
   end

   for (genvar k = 1; k <= N; k++) begin : g_step
      logic [DR:0]   trial;
      logic [DR+1:0] diff;
      logic          take;
      assign trial = {rem_ff[k-1], quo_ff[k-1][N-1]};
      assign diff  = {1'b0, trial} - {2'b00, dsor_ff[k-1]};
      assign take  = ~diff[DR+1];
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_ff[k-1];
         end
         if (en) begin
            rem_ff[k]  <= take ? diff[DR-1:0] : trial[DR-1:0];
            quo_ff[k]  <= {quo_ff[k-1][N-2:0], take};
            dsor_ff[k] <= dsor_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
            tag_ff[k]  <= tag_ff[k-1];
         end
      end
   end

   // sign restore
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= valid_ff[N];
      end
      if (en) begin
         out_quot_ff <= neg_ff[N] ? -$signed({1'b0, quo_ff[N]}) : $signed({1'b0, quo_ff[N]});
         out_tag_ff  <= tag_ff[N];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_quot  = out_quot_ff;
   assign out_tag   = out_tag_ff;

endmodule

// ===== sim/box_to_image_rect_projection_unit_test.sv =====
// Self-checking testbench for box_to_image_rect_projection_unit.
// Uses brp_pkg for widths and register indexes. A local rectangle predictor
// checks every result transaction in order, under random idling and back-pressure.
`timescale 1ns / 1ps
module box_to_image_rect_projection_unit_test;

   typedef struct {
      logic signed [brp_pkg::COORD_W-1:0] min_x, max_x, min_y, max_y, min_z, max_z;
   } box_type;

   typedef struct packed {
      logic                      valid;
      logic [brp_pkg::PIX_W-1:0] left, top, width, height;
   } rect_type;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 100;
   localparam int HOLD_CYCLES = 400;

   logic clock = 0;
   logic reset = 1;
   logic csr_write_enable = 0;
   logic [brp_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [brp_pkg::CSR_DATA_W-1:0] csr_write_data = '0;
   logic req_valid = 0;
   logic req_stall;
   logic signed [brp_pkg::COORD_W-1:0] req_box_min_x = 0, req_box_max_x = 0;
   logic signed [brp_pkg::COORD_W-1:0] req_box_min_y = 0, req_box_max_y = 0;
   logic signed [brp_pkg::COORD_W-1:0] req_box_min_z = 0, req_box_max_z = 0;
   logic rsp_valid;
   logic rsp_stall = 1;
   logic rsp_rect_valid;
   logic [brp_pkg::PIX_W-1:0] rsp_rect_left, rsp_rect_top, rsp_rect_width, rsp_rect_height;

   // Shadow of the configuration registers
   logic [brp_pkg::CSR_DATA_W-1:0] coef_pair_shadow [brp_pkg::PAIR_NUM];
   logic [brp_pkg::IMG_SIZE_W-1:0] image_size_shadow;
   logic [brp_pkg::MIN_DEPTH_W-1:0] min_depth_shadow;

   rect_type pending_rects [$];
   int mismatch_count = 0;
   int rect_count = 0;
   int valid_rect_count = 0;
   int box_count = 0;
   int cycle_count = 0;
   bit quiet_mode = 0;      // no idling on either side
   bit hold_request = 0;    // receiver holds off for a long stretch

   box_to_image_rect_projection_unit dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Run-away guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d rects pending", cycle_count,
                  pending_rects.size());
         $display("FAIL box_to_image_rect_projection_unit");
         $finish;
      end
   end

   // Matrix element k, sign-extended Q15.16
   function automatic longint matrix_coef(int k);
      logic [brp_pkg::CSR_DATA_W-1:0] pair;
      pair = coef_pair_shadow[k / 2];
      return longint'($signed((k % 2) ? pair[63:32] : pair[31:0]));
   endfunction

   // Row dot product in Q.24; translation column scaled by 256
   function automatic longint project_row(int row, longint x, longint y, longint z);
      return matrix_coef(4*row) * x + matrix_coef(4*row+1) * y
           + matrix_coef(4*row+2) * z + matrix_coef(4*row+3) * 256;
   endfunction

   function automatic rect_type predict_rect(box_type box);
      rect_type rect;
      longint xs [2], ys [2], zs [2];
      longint x, y, z, w, u, v, depth_floor, lim_u, lim_v, l, t, r, b;
      longint u_lo, u_hi, v_lo, v_hi;
      int used;
      rect = '0;
      used = 0;
      u_lo = 0; u_hi = 0; v_lo = 0; v_hi = 0;
      xs[0] = box.min_x; xs[1] = box.max_x;
      ys[0] = box.min_y; ys[1] = box.max_y;
      zs[0] = box.min_z; zs[1] = box.max_z;
      depth_floor = longint'(min_depth_shadow) * 256;
      for (int c = 0; c < brp_pkg::CORNER_COUNT; c++) begin
         x = xs[(c >> 2) & 1];
         y = ys[(c >> 1) & 1];
         z = zs[c & 1];
         w = project_row(2, x, y, z);
         if (w <= 0 || w < depth_floor) continue;   // behind or too near
         u = (project_row(0, x, y, z) * 16) / w;
         v = (project_row(1, x, y, z) * 16) / w;
         if (used == 0) begin
            u_lo = u; u_hi = u; v_lo = v; v_hi = v;
         end else begin
            if (u < u_lo) u_lo = u;
            if (u > u_hi) u_hi = u;
            if (v < v_lo) v_lo = v;
            if (v > v_hi) v_hi = v;
         end
         used++;
      end
      if (used == 0 || u_hi <= u_lo || v_hi <= v_lo) return rect;
      lim_u = longint'(image_size_shadow[15:0]) * 16;
      lim_v = longint'(image_size_shadow[31:16]) * 16;
      if (lim_u > brp_pkg::PIX_MAX) lim_u = brp_pkg::PIX_MAX;
      if (lim_v > brp_pkg::PIX_MAX) lim_v = brp_pkg::PIX_MAX;
      l = (u_lo < 0) ? 0 : u_lo;
      t = (v_lo < 0) ? 0 : v_lo;
      r = (u_hi > lim_u) ? lim_u : u_hi;
      b = (v_hi > lim_v) ? lim_v : v_hi;
      if (r <= l || b <= t) return rect;
      rect.valid = 1;
      rect.left = l[15:0];
      rect.top = t[15:0];
      rect.width = 16'(r - l);
      rect.height = 16'(b - t);
      return rect;
   endfunction

   // Receiver: check each accepted result, then pick the next stall value
   always @(posedge clock) begin
      rect_type seen, want;
      int hold_left;
      bit hold_done;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = {rsp_rect_valid, rsp_rect_left, rsp_rect_top, rsp_rect_width, rsp_rect_height};
         rect_count++;
         if (seen.valid) valid_rect_count++;
         if (pending_rects.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("Unexpected rect transaction %p", seen);
         end else begin
            want = pending_rects.pop_front();
            if (seen !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"Rect mismatch: expected v=%0b l=%0d t=%0d w=%0d h=%0d,",
                            " got v=%0b l=%0d t=%0d w=%0d h=%0d"},
                           want.valid, want.left, want.top, want.width, want.height,
                           seen.valid, seen.left, seen.top, seen.width, seen.height);
            end
         end
      end
      // long hold-off, counted here so the sender keeps offering boxes meanwhile
      if (hold_request && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1;
      end else if (reset) begin
         rsp_stall <= 1;
      end else begin
         rsp_stall <= !quiet_mode && ($urandom % 100 < 33);
      end
   end

   // Sends one box transaction; returns right after the accepting edge
   task automatic send_box(box_type box);
      if (!quiet_mode && ($urandom % 100 < 33)) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1;
      req_box_min_x <= box.min_x; req_box_max_x <= box.max_x;
      req_box_min_y <= box.min_y; req_box_max_y <= box.max_y;
      req_box_min_z <= box.min_z; req_box_max_z <= box.max_z;
      do @(posedge clock); while (req_stall);
      pending_rects = {pending_rects, predict_rect(box)};
      box_count++;
   endtask

   // Waits until every rect has come back and the pipe has emptied
   task automatic drain;
      req_valid <= 0;
      @(posedge clock);
      while (pending_rects.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes all registers from the shadow; only while idle
   task automatic load_registers;
      for (int i = 0; i < 8; i++) begin
         csr_write_enable <= 1;
         csr_index <= brp_pkg::CSR_INDEX_W'(i);
         if (i <= brp_pkg::REG_COEF_PAIR_5)
            csr_write_data <= coef_pair_shadow[i];
         else if (i == brp_pkg::REG_IMAGE_SIZE)
            csr_write_data <= brp_pkg::CSR_DATA_W'(image_size_shadow);
         else
            csr_write_data <= brp_pkg::CSR_DATA_W'(min_depth_shadow);
         @(posedge clock);
      end
      csr_write_enable <= 0;
      @(posedge clock);
   endtask

   function automatic logic [63:0] pack_pair(int lo, int hi);
      return {32'(hi), 32'(lo)};
   endfunction

   // Forward-looking camera: depth along x, u from -y, v from -z (Q15.16)
   task automatic set_camera(int focal, int cen_u, int cen_v);
      coef_pair_shadow[0] = pack_pair(cen_u * 65536, -focal * 65536);
      coef_pair_shadow[1] = pack_pair(0, 0);
      coef_pair_shadow[2] = pack_pair(cen_v * 65536, 0);
      coef_pair_shadow[3] = pack_pair(-focal * 65536, 0);
      coef_pair_shadow[4] = pack_pair(65536, 0);
      coef_pair_shadow[5] = pack_pair(0, 0);
   endtask

   function automatic box_type make_box(int x0, int x1, int y0, int y1, int z0, int z1);
      box_type box;
      box.min_x = 16'(x0); box.max_x = 16'(x1);
      box.min_y = 16'(y0); box.max_y = 16'(y1);
      box.min_z = 16'(z0); box.max_z = 16'(z1);
      return box;
   endfunction

   function automatic int clamp_coord(int value);
      return (value > 32767) ? 32767 : (value < -32768) ? -32768 : value;
   endfunction

   // Box mostly in front of the camera, metres in Q8.8
   function automatic box_type random_scene_box();
      int x0, y0, z0;
      x0 = $urandom_range(0, 16000) - 1000;
      y0 = $urandom_range(0, 12800) - 6400;
      z0 = $urandom_range(0, 1536) - 768;
      return make_box(x0, clamp_coord(x0 + $urandom_range(0, 1500)),
                      y0, clamp_coord(y0 + $urandom_range(0, 1500)),
                      z0, clamp_coord(z0 + $urandom_range(0, 800)));
   endfunction

   function automatic box_type random_noise_box();
      return make_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
   endfunction

   function automatic box_type random_box();
      return ($urandom % 100 < 85) ? random_scene_box() : random_noise_box();
   endfunction

   // All coefficients zero after reset: no corner has positive depth
   task automatic test_reset_defaults;
      for (int i = 0; i < 4; i++) send_box(random_box());
      drain();
   endtask

   task automatic test_directed_cases;
      set_camera(1000, 960, 540);
      load_registers();
      send_box(make_box(2560, 3072, -256, 256, -128, 128));    // plain box ahead
      send_box(make_box(512, 768, -2560, 2560, -2560, 2560));  // clipped on all sides
      send_box(make_box(-3072, -2560, -256, 256, -128, 128));  // wholly behind
      send_box(make_box(-256, 1280, -256, 256, -128, 128));    // partly behind
      send_box(make_box(2560, 2560, 256, 256, 0, 0));          // single point
      send_box(make_box(2560, 3072, 256, 256, -128, 128));     // zero width
      send_box(make_box(3072, 2560, 256, -256, 128, -128));    // bounds swapped
      send_box(make_box(512, 768, -5120, -4096, -128, 128));   // right of image
      send_box(make_box(512, 768, 4096, 5120, -128, 128));     // left of image
      send_box(make_box(-32768, 32767, -32768, 32767, -32768, 32767));
      send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
      send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768));
      send_box(make_box(1, 32767, -1, 1, -1, 1));
      drain();
      // corners nearer than 10 m are dropped
      min_depth_shadow = 24'(10 * 65536);
      load_registers();
      send_box(make_box(1280, 3840, -512, 512, -256, 256));
      send_box(make_box(1280, 2304, -512, 512, -256, 256));
      drain();
      min_depth_shadow = '1;   // nothing is deep enough
      load_registers();
      send_box(make_box(1280, 3840, -512, 512, -256, 256));
      send_box(make_box(-32768, 32767, -32768, 32767, -32768, 32767));
      drain();
      min_depth_shadow = '0;
   endtask

   // Zero-size image, saturated bounds, and a narrow, tall sensor
   task automatic test_image_extremes;
      logic [brp_pkg::IMG_SIZE_W-1:0] sizes [3];
      sizes[0] = '0;
      sizes[1] = '1;
      sizes[2] = {16'd4097, 16'd3};
      for (int s = 0; s < 3; s++) begin
         image_size_shadow = sizes[s];
         load_registers();
         send_box(make_box(512, 768, -2560, 2560, -2560, 2560));
         send_box(make_box(256, 300, -32768, 32767, -32768, 32767));
         send_box(make_box(2560, 3072, -256, 256, -128, 128));
         drain();
      end
   endtask

   task automatic test_random_scenes;
      for (int phase = 0; phase < 5; phase++) begin
         set_camera($urandom_range(200, 2000), $urandom_range(0, 2000),
                    $urandom_range(0, 1200));
         image_size_shadow = (phase == 0) ? brp_pkg::IMAGE_SIZE_RESET : $urandom;
         if (phase != 0 && $urandom % 2) image_size_shadow[15:12] = 0;
         min_depth_shadow = (phase < 2) ? '0 : 24'($urandom_range(0, 20 * 65536));
         load_registers();
         quiet_mode = (phase == 1);
         for (int i = 0; i < 150; i++) send_box(random_box());
         quiet_mode = 0;
         drain();
      end
   endtask

   // Arbitrary matrices, each element pair either random or left as the camera term
   task automatic test_random_matrix;
      for (int phase = 0; phase < 3; phase++) begin
         set_camera(1000, 960, 540);
         for (int p = 0; p < brp_pkg::PAIR_NUM; p++)
            if ($urandom % 2 || phase == 0) coef_pair_shadow[p] = {$urandom, $urandom};
         image_size_shadow = $urandom;
         min_depth_shadow = 24'($urandom);
         if (phase == 2) min_depth_shadow = '0;
         load_registers();
         for (int i = 0; i < 60; i++) send_box(random_box());
         drain();
      end
   endtask

   // Receiver holds off long enough for the pipe to fill and stall the input
   task automatic test_backpressure;
      set_camera(800, 640, 360);
      image_size_shadow = {16'd720, 16'd1280};
      min_depth_shadow = 24'(65536);
      load_registers();
      hold_request = 1;
      for (int i = 0; i < 80; i++) send_box(random_scene_box());
      drain();
   endtask

   initial begin
      for (int p = 0; p < brp_pkg::PAIR_NUM; p++) coef_pair_shadow[p] = '0;
      image_size_shadow = brp_pkg::IMAGE_SIZE_RESET;
      min_depth_shadow = '0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_reset_defaults();
      test_directed_cases();
      test_image_extremes();
      test_random_scenes();
      test_random_matrix();
      test_backpressure();
      $display("Covered %0d boxes over reset, camera, random-matrix and clipping setups,",
               box_count);
      $display("%0d rects checked (%0d valid), %0d mismatches", rect_count,
               valid_rect_count, mismatch_count);
      if (mismatch_count == 0 && pending_rects.size() == 0) begin
         $display("PASS box_to_image_rect_projection_unit");
      end else begin
         $display("FAIL box_to_image_rect_projection_unit");
      end
      $finish;
   end

endmodule
